>>> rtl/wtw_pkg.sv
// shared types, constants and codes for the weekly time window trigger table
package wtw_pkg;

  localparam int TableEntriesDef = 16;
  localparam int MaxResults      = 16;
  localparam int CountW          = $clog2(MaxResults + 1);

  localparam logic OpTick  = 1'b0;
  localparam logic OpWrite = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [3:0]  entry_index;
    logic [10:0] start_minute;
    logic [10:0] end_minute;
    logic [6:0]  day_mask;
    logic        entry_enabled;
    logic [7:0]  profile_id;
    logic [10:0] current_minute;
    logic [2:0]  current_day;
  } wtw_in_t;

  typedef struct packed {
    logic [7:0] activated_profile;
    logic       last_of_run;
  } wtw_out_t;

  // stored part of an entry; the enable bit lives in flip-flops
  typedef struct packed {
    logic [10:0] start_minute;
    logic [10:0] end_minute;
    logic [6:0]  day_mask;
    logic [7:0]  profile_id;
  } wtw_entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StDrain,
    StFinish
  } wtw_state_e;

  typedef struct packed {
    logic write_en;
    logic load_tick;
    logic rd_en;
    logic finish;
  } wtw_cmd_t;

endpackage

>>> rtl/wtw_ctrl.sv
// controller: sequences writes and the walk over the table on a tick
module wtw_ctrl #(
  parameter int TABLE_ENTRIES = wtw_pkg::TableEntriesDef,
  parameter int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             operation_i,
  output logic             busy_o,
  output wtw_pkg::wtw_cmd_t cmd_o,
  output logic [IdxW-1:0]  rd_addr_o
);

  localparam logic [IdxW:0] LastIdx = (IdxW + 1)'(TABLE_ENTRIES - 1);

  wtw_pkg::wtw_state_e state_q, state_d;
  logic [IdxW:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wtw_pkg::StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      wtw_pkg::StIdle: begin
        idx_d = '0;
        if (start_i && operation_i == wtw_pkg::OpTick) begin
          state_d = wtw_pkg::StWalk;
        end
      end
      wtw_pkg::StWalk: begin
        idx_d = idx_q + (IdxW + 1)'(1);
        if (idx_q == LastIdx) begin
          state_d = wtw_pkg::StDrain;
        end
      end
      wtw_pkg::StDrain:  state_d = wtw_pkg::StFinish;
      wtw_pkg::StFinish: state_d = wtw_pkg::StIdle;
      default:           state_d = wtw_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o     = '0;
    busy_o    = 1'b1;
    rd_addr_o = idx_q[IdxW-1:0];
    case (state_q)
      wtw_pkg::StIdle: begin
        busy_o          = 1'b0;
        cmd_o.write_en  = start_i && (operation_i == wtw_pkg::OpWrite);
        cmd_o.load_tick = start_i && (operation_i == wtw_pkg::OpTick);
      end
      wtw_pkg::StWalk:   cmd_o.rd_en  = 1'b1;
      wtw_pkg::StDrain:  cmd_o.rd_en  = 1'b0;
      wtw_pkg::StFinish: cmd_o.finish = 1'b1;
      default:           busy_o       = 1'b1;
    endcase
  end

endmodule

>>> rtl/wtw_dpath.sv
// datapath: entry store, window match and result sequencing
module wtw_dpath #(
  parameter int TABLE_ENTRIES = wtw_pkg::TableEntriesDef,
  parameter int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wtw_pkg::wtw_cmd_t cmd_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  input  wtw_pkg::wtw_in_t  in_i,
  output logic              result_valid_o,
  output wtw_pkg::wtw_out_t result_o
);

  wtw_pkg::wtw_entry_t mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] enabled_q;

  wtw_pkg::wtw_entry_t rd_data_q;
  logic rd_en_q, eval_q;

  logic [10:0] minute_q;
  logic [2:0]  day_q;

  logic       last_valid_q, last_valid_d;
  logic [7:0] last_prof_q, last_prof_d;
  logic       pend_valid_q, pend_valid_d;
  logic [7:0] pend_prof_q, pend_prof_d;
  logic [wtw_pkg::CountW-1:0] count_q, count_d;

  logic [IdxW-1:0] wr_addr;
  logic            wr_in_range;

  assign wr_addr     = IdxW'(in_i.entry_index);
  assign wr_in_range = 32'(in_i.entry_index) < TABLE_ENTRIES;

  // entry store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en && wr_in_range) begin
      mem[wr_addr] <= '{start_minute: in_i.start_minute, end_minute: in_i.end_minute,
                        day_mask: in_i.day_mask, profile_id: in_i.profile_id};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
    if (cmd_i.load_tick) begin
      minute_q <= in_i.current_minute;
      day_q    <= in_i.current_day;
    end
    pend_prof_q <= pend_prof_d;
    last_prof_q <= last_prof_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= '0;
      rd_en_q      <= 1'b0;
      eval_q       <= 1'b0;
      last_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      count_q      <= '0;
    end else begin
      if (cmd_i.write_en && wr_in_range) begin
        enabled_q[wr_addr] <= in_i.entry_enabled;
      end
      if (cmd_i.rd_en) begin
        rd_en_q <= enabled_q[rd_addr_i];
      end
      eval_q       <= cmd_i.rd_en;
      last_valid_q <= last_valid_d;
      pend_valid_q <= pend_valid_d;
      count_q      <= count_d;
    end
  end

  // window and day match
  logic day_hit, win_hit, activate;
  logic ge_start, lt_end;

  assign day_hit  = (day_q != 3'd7) && rd_data_q.day_mask[day_q];
  assign ge_start = minute_q >= rd_data_q.start_minute;
  assign lt_end   = minute_q < rd_data_q.end_minute;

  always_comb begin
    if (rd_data_q.end_minute == 11'd0) begin
      win_hit = ge_start;
    end else if (rd_data_q.end_minute < rd_data_q.start_minute) begin
      win_hit = ge_start || lt_end;   // wraps past midnight
    end else begin
      win_hit = ge_start && lt_end;
    end
  end

  assign activate = eval_q && rd_en_q && day_hit && win_hit &&
                    !(last_valid_q && (last_prof_q == rd_data_q.profile_id));

  // results held back one step so the final one can be flagged
  always_comb begin
    last_valid_d   = last_valid_q;
    last_prof_d    = last_prof_q;
    pend_valid_d   = pend_valid_q;
    pend_prof_d    = pend_prof_q;
    count_d        = count_q;
    result_valid_o = 1'b0;
    result_o.activated_profile = pend_prof_q;
    result_o.last_of_run       = 1'b0;
    if (cmd_i.load_tick) begin
      pend_valid_d = 1'b0;
      count_d      = '0;
    end else if (activate) begin
      last_valid_d = 1'b1;
      last_prof_d  = rd_data_q.profile_id;
      if (32'(count_q) < wtw_pkg::MaxResults) begin
        result_valid_o = pend_valid_q;
        pend_valid_d   = 1'b1;
        pend_prof_d    = rd_data_q.profile_id;
        count_d        = count_q + wtw_pkg::CountW'(1);
      end
    end else if (cmd_i.finish) begin
      result_valid_o       = pend_valid_q;
      result_o.last_of_run = 1'b1;
      pend_valid_d         = 1'b0;
    end
  end

endmodule

>>> rtl/weekly_time_window_trigger_table.sv
// top level of the weekly time window trigger table
// a write transfer is accepted while idle; busy stays low and the next item may follow at once
// a tick transfer holds busy through the walk, one read per entry on the single store read
// port, then a drain state to match the last entry and a finish state to flag the final result
// results appear as single-cycle strobes while busy; the receiver cannot stall them
// reset clears all enables and the last activated profile; the store needs no sweep
module weekly_time_window_trigger_table #(
  parameter int TABLE_ENTRIES = wtw_pkg::TableEntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  wtw_pkg::wtw_in_t  in_i,
  output logic              result_valid_o,
  output wtw_pkg::wtw_out_t result_o
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  wtw_pkg::wtw_cmd_t cmd;
  logic [IdxW-1:0]   rd_addr;
  logic              start_ok;

  // a transfer only counts while idle
  assign start_ok = start_i && !busy_o;

  // sequencer: walks the entries in index order on a tick
  wtw_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IdxW         (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_ok),
    .operation_i(in_i.operation),
    .busy_o     (busy_o),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  // store, matcher and output staging
  wtw_dpath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IdxW         (IdxW)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .in_i          (in_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

>>> test/tb_weekly_time_window_trigger_table.sv
// self-checking testbench for the weekly time window trigger table
module tb_weekly_time_window_trigger_table;
  timeunit 1ns;
  timeprecision 1ps;

  // a tick keeps busy high for the walk, drain and finish states; this is the settle margin
  localparam int TickLatency = wtw_pkg::TableEntriesDef + 4;
  // upper bound on cycles to wait for outstanding activations
  localparam int DrainLimit  = 4000;
  // depth of the expected-result ring
  localparam int WantDepth   = 256;

  // predictor copy of one schedule slot
  typedef struct packed {
    logic [10:0] from_minute;
    logic [10:0] to_minute;
    logic [6:0]  days;
    logic        enabled;
    logic [7:0]  profile;
  } slot_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  wtw_pkg::wtw_in_t  in_i;
  logic              result_valid_o;
  wtw_pkg::wtw_out_t result_o;

  // predictor state
  slot_t             schedule_copy [wtw_pkg::TableEntriesDef];
  logic [7:0]        last_active;
  logic              last_active_set;
  wtw_pkg::wtw_out_t want_buf [WantDepth];
  int                want_head = 0;
  int                want_tail = 0;

  int fault_count     = 0;
  int transfer_count  = 0;
  int tick_count      = 0;
  int activation_seen = 0;
  int sender_gap_pct  = 0;

  weekly_time_window_trigger_table #(
    .TABLE_ENTRIES (wtw_pkg::TableEntriesDef)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // number of expected results still outstanding
  function automatic int want_level();
    return want_tail - want_head;
  endfunction

  // append one expected result to the ring
  task automatic add_expected(input wtw_pkg::wtw_out_t r);
    want_buf[want_tail % WantDepth] = r;
    want_tail++;
  endtask

  // window test: end of zero is open-ended, end below start wraps past midnight,
  // and weekday seven has no mask bit so it never matches
  function automatic logic window_match(slot_t s, logic [10:0] m, logic [2:0] d);
    if (d == 3'd7) return 1'b0;
    if (!s.days[d]) return 1'b0;
    if (s.to_minute == '0) return m >= s.from_minute;
    if (s.to_minute < s.from_minute) return (m >= s.from_minute) || (m < s.to_minute);
    return (m >= s.from_minute) && (m < s.to_minute);
  endfunction

  // apply one accepted transfer to the predictor and queue the activations it causes
  task automatic advance_schedule_model(input wtw_pkg::wtw_in_t item);
    wtw_pkg::wtw_out_t run_buf [wtw_pkg::MaxResults];
    int                run_len;
    wtw_pkg::wtw_out_t act;
    slot_t             s;
    run_len = 0;
    if (item.operation == wtw_pkg::OpWrite) begin
      if (int'(item.entry_index) < wtw_pkg::TableEntriesDef) begin
        s.from_minute = item.start_minute;
        s.to_minute   = item.end_minute;
        s.days        = item.day_mask;
        s.enabled     = item.entry_enabled;
        s.profile     = item.profile_id;
        schedule_copy[item.entry_index] = s;
      end
    end else begin
      tick_count++;
      // walk from slot 0 upward; a repeat of the last profile is suppressed
      for (int i = 0; i < wtw_pkg::TableEntriesDef; i++) begin
        s = schedule_copy[i];
        if (s.enabled && window_match(s, item.current_minute, item.current_day) &&
            !(last_active_set && last_active == s.profile)) begin
          last_active     = s.profile;
          last_active_set = 1'b1;
          // past the result limit the profile still becomes the last activated
          if (run_len < wtw_pkg::MaxResults) begin
            act.activated_profile = s.profile;
            act.last_of_run       = 1'b0;
            run_buf[run_len]      = act;
            run_len++;
          end
        end
      end
      if (run_len != 0) run_buf[run_len - 1].last_of_run = 1'b1;
      for (int k = 0; k < run_len; k++) add_expected(run_buf[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker: every strobe is one result transfer, there is no back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    wtw_pkg::wtw_out_t want;
    if (rst_ni && result_valid_o) begin
      activation_seen++;
      if (want_level() == 0) begin
        $error("unexpected activation: profile %0d, last_of_run %0b",
               result_o.activated_profile, result_o.last_of_run);
        fault_count++;
      end else begin
        want = want_buf[want_head % WantDepth];
        want_head++;
        if (result_o.activated_profile !== want.activated_profile) begin
          $error("activated_profile: expected %0d, got %0d",
                 want.activated_profile, result_o.activated_profile);
          fault_count++;
        end
        if (result_o.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, result_o.last_of_run);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // fields that the operation ignores carry random noise
  function automatic wtw_pkg::wtw_in_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(wtw_pkg::wtw_in_t)-1:0];
  endfunction

  function automatic wtw_pkg::wtw_in_t make_write(input logic [3:0] idx, input logic [10:0] s,
                                                  input logic [10:0] e, input logic [6:0] mask,
                                                  input logic en, input logic [7:0] prof);
    wtw_pkg::wtw_in_t item;
    item               = noise_item();
    item.operation     = wtw_pkg::OpWrite;
    item.entry_index   = idx;
    item.start_minute  = s;
    item.end_minute    = e;
    item.day_mask      = mask;
    item.entry_enabled = en;
    item.profile_id    = prof;
    return item;
  endfunction

  function automatic wtw_pkg::wtw_in_t make_tick(input logic [10:0] m, input logic [2:0] d);
    wtw_pkg::wtw_in_t item;
    item                = noise_item();
    item.operation      = wtw_pkg::OpTick;
    item.current_minute = m;
    item.current_day    = d;
    return item;
  endfunction

  // one input transfer: optional random gap, then hold start until busy is low.
  // entered just after a falling edge and left just after one, so start may stay
  // high straight into the next item
  task automatic send_item(input wtw_pkg::wtw_in_t item);
    while ($urandom_range(99) < sender_gap_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    in_i    = item;
    do @(posedge clk_i); while (busy_o);
    // transfer taken at this edge
    advance_schedule_model(item);
    transfer_count++;
    @(negedge clk_i);
  endtask

  // sender holds off until all expected activations have arrived, then lets the walk settle
  task automatic wait_until_drained();
    int guard;
    guard   = 0;
    start_i = 1'b0;
    while (want_level() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TickLatency) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random write with a bias towards small profile numbers so repeats get suppressed
  function automatic wtw_pkg::wtw_in_t random_write();
    logic [10:0] s;
    logic [10:0] e;
    logic [6:0]  mask;
    logic [7:0]  prof;
    int          pick;
    s    = ($urandom_range(9) == 0) ? 11'($urandom_range(2047, 1440)) : 11'($urandom_range(1439));
    pick = $urandom_range(19);
    if (pick < 5)       e = '0;
    else if (pick < 18) e = 11'($urandom_range(1439));
    else                e = 11'($urandom_range(2047, 1440));
    mask = ($urandom_range(1) == 0) ? 7'h7f : 7'($urandom);
    prof = ($urandom_range(4) < 3) ? 8'($urandom_range(7)) : 8'($urandom);
    return make_write(4'($urandom), s, e, mask, 1'($urandom_range(99) < 85), prof);
  endfunction

  // tick aimed at a stored window most of the time, otherwise anywhere
  function automatic wtw_pkg::wtw_in_t random_tick();
    slot_t       s;
    logic [10:0] m;
    logic [2:0]  d;
    if ($urandom_range(9) < 7) begin
      s = schedule_copy[$urandom_range(wtw_pkg::TableEntriesDef - 1)];
      m = s.from_minute + 11'($urandom_range(40));
      d = 3'($urandom_range(6));
      if (s.days != '0 && $urandom_range(1) == 0) begin
        while (!s.days[d]) d = (d == 3'd6) ? 3'd0 : d + 3'd1;
      end
    end else begin
      m = ($urandom_range(9) == 0) ? 11'($urandom_range(2047, 1440)) : 11'($urandom_range(1439));
      d = ($urandom_range(9) == 0) ? 3'd7 : 3'($urandom_range(6));
    end
    return make_tick(m, d);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked windows covering the edge cases of the matching rule
  task automatic test_directed_windows();
    // empty table after reset: nothing fires
    send_item(make_tick(11'd0, 3'd0));
    // profile zero fires on the very first activation
    send_item(make_write(4'd0, 11'd0, 11'd0, 7'h7f, 1'b1, 8'h00));
    send_item(make_tick(11'd0, 3'd0));
    // same profile again is suppressed
    send_item(make_tick(11'd720, 3'd3));
    // last slot, last minute, last day, top profile
    send_item(make_write(4'd15, 11'd1439, 11'd0, 7'h7f, 1'b1, 8'hff));
    send_item(make_tick(11'd1439, 3'd6));
    // window wrapping past midnight, sunday only
    send_item(make_write(4'd1, 11'd1380, 11'd60, 7'h01, 1'b1, 8'ha5));
    send_item(make_tick(11'd30, 3'd0));
    send_item(make_tick(11'd1400, 3'd0));
    // wrapped end is exclusive
    send_item(make_tick(11'd60, 3'd0));
    // weekday seven matches nothing
    send_item(make_tick(11'd1439, 3'd7));
    // plain window on monday, end exclusive
    send_item(make_write(4'd2, 11'd100, 11'd200, 7'h02, 1'b1, 8'h5a));
    send_item(make_tick(11'd199, 3'd1));
    send_item(make_tick(11'd200, 3'd1));
    // minutes beyond a day are compared unclamped
    send_item(make_write(4'd3, 11'd2047, 11'd1500, 7'h7f, 1'b1, 8'h33));
    send_item(make_tick(11'd2047, 3'd5));
    // disabled slot drops out
    send_item(make_write(4'd0, 11'd0, 11'd0, 7'h7f, 1'b0, 8'h00));
    send_item(make_tick(11'd2047, 3'd5));
    // saturday only, widest end
    send_item(make_write(4'd4, 11'd0, 11'd2047, 7'h40, 1'b1, 8'h80));
    send_item(make_tick(11'd1000, 3'd6));
  endtask

  // every slot open all week with distinct profiles, so one tick fires the whole table
  task automatic test_full_table_run();
    logic [7:0] base;
    base = 8'($urandom);
    for (int i = 0; i < wtw_pkg::TableEntriesDef; i++) begin
      send_item(make_write(4'(i), 11'($urandom_range(200)), 11'd0, 7'h7f, 1'b1,
                           base + 8'(i)));
    end
    send_item(make_tick(11'd1000, 3'($urandom_range(6))));
  endtask

  // mostly short write bursts followed by ticks, with some fully random noise
  task automatic test_random_schedule(input int item_total);
    int sent;
    int burst;
    sent = 0;
    while (sent < item_total) begin
      if ($urandom_range(9) == 0) begin
        send_item(noise_item());
        sent++;
      end else begin
        burst = $urandom_range(3);
        repeat (burst) send_item(random_write());
        sent += burst;
        burst = $urandom_range(4, 1);
        repeat (burst) send_item(random_tick());
        sent += burst;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    in_i            = '0;
    last_active     = '0;
    last_active_set = 1'b0;
    foreach (schedule_copy[i]) schedule_copy[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // light sender gaps
    sender_gap_pct = 15;
    test_directed_windows();
    wait_until_drained();
    test_random_schedule(55);
    wait_until_drained();

    // heavy sender gaps
    sender_gap_pct = 84;
    test_full_table_run();
    test_random_schedule(55);
    wait_until_drained();

    // back-to-back transfers
    sender_gap_pct = 0;
    test_full_table_run();
    test_random_schedule(55);
    wait_until_drained();

    if (want_level() != 0) begin
      $error("%0d expected activations never arrived", want_level());
      fault_count += want_level();
    end

    $display("run: %0d transfers (%0d ticks), %0d activations compared",
             transfer_count, tick_count, activation_seen);
    $display("included wrap-round, open-ended and out-of-range windows and full-table runs");
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/wtw_pkg.sv
rtl/wtw_ctrl.sv
rtl/wtw_dpath.sv
rtl/weekly_time_window_trigger_table.sv
test/tb_weekly_time_window_trigger_table.sv
